// ===== design/tpsm_pkg.sv =====
package tpsm_pkg;

    // Type tags carried in bits 33:32 of every stack cell.
    localparam logic [1:0] TAG_INT  = 2'd0;
    localparam logic [1:0] TAG_REAL = 2'd1;
    localparam logic [1:0] TAG_CHAR = 2'd2;
    localparam logic [1:0] TAG_BOOL = 2'd3;

    // Instruction opcodes.
    localparam logic [2:0] OP_LIT = 3'd0;
    localparam logic [2:0] OP_LOD = 3'd1;
    localparam logic [2:0] OP_STO = 3'd2;
    localparam logic [2:0] OP_CAL = 3'd3;
    localparam logic [2:0] OP_INT = 3'd4;
    localparam logic [2:0] OP_JMP = 3'd5;
    localparam logic [2:0] OP_JPC = 3'd6;
    localparam logic [2:0] OP_OPR = 3'd7;

    // OPR function numbers.
    localparam logic [31:0] FN_RET     = 32'd0;
    localparam logic [31:0] FN_NEG     = 32'd1;
    localparam logic [31:0] FN_ADD     = 32'd2;
    localparam logic [31:0] FN_SUB     = 32'd3;
    localparam logic [31:0] FN_MUL     = 32'd4;
    localparam logic [31:0] FN_DIV     = 32'd5;
    localparam logic [31:0] FN_ODD     = 32'd6;
    localparam logic [31:0] FN_MOD     = 32'd7;
    localparam logic [31:0] FN_EQ      = 32'd8;
    localparam logic [31:0] FN_NE      = 32'd9;
    localparam logic [31:0] FN_LT      = 32'd10;
    localparam logic [31:0] FN_GE      = 32'd11;
    localparam logic [31:0] FN_GT      = 32'd12;
    localparam logic [31:0] FN_LE      = 32'd13;
    localparam logic [31:0] FN_PRINT   = 32'd14;
    localparam logic [31:0] FN_NEWLINE = 32'd15;
    localparam logic [31:0] FN_AND     = 32'd17;
    localparam logic [31:0] FN_OR      = 32'd18;
    localparam logic [31:0] FN_NOT     = 32'd19;
    localparam logic [31:0] FN_IDIV    = 32'd20;
    localparam logic [31:0] FN_RD_INT  = 32'd161;
    localparam logic [31:0] FN_RD_CHAR = 32'd162;
    localparam logic [31:0] FN_RD_REAL = 32'd163;
    localparam logic [31:0] FN_RD_BOOL = 32'd164;

    // Offset value that selects indexed LOD and STO.
    localparam logic [31:0] OFS_INDEXED = 32'hFFFF_FFFF;

    // Divider operand widths: a Q16.16 value shifted up by 16 over a 32-bit divisor.
    localparam int DVD_W = 48;
    localparam int DVS_W = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WALK_RD,
        S_WALK_WB,
        S_RD1,
        S_RD2,
        S_CAP2,
        S_PREP,
        S_MUL,
        S_DIV,
        S_EXEC,
        S_COMMIT,
        S_CAL2
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic decode;
        logic walk_rd;
        logic walk_wb;
        logic rd1;
        logic rd2;
        logic cap2;
        logic prep;
        logic mul;
        logic div_start;
        logic exec;
        logic commit;
        logic cal_link;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_walk;
        logic is_cal;
        logic lev_zero;
        logic lev_last;
        logic div_op;
        logic div_busy;
        logic out_free;
    } stat_t;

endpackage

// ===== design/tpsm_divider.sv =====
module tpsm_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [tpsm_pkg::DVD_W-1:0]  dividend,
    input  logic [tpsm_pkg::DVS_W-1:0]  divisor,
    output logic                        busy,
    output logic [tpsm_pkg::DVD_W-1:0]  quotient,
    output logic [tpsm_pkg::DVS_W-1:0]  remainder
);
    import tpsm_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DVD_W - 1);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Unsigned magnitude datapath, one quotient bit per cycle.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/tpsm_datapath.sv =====
module tpsm_datapath #(
    parameter  int STACK_DEPTH   = 1024,
    parameter  int PROGRAM_DEPTH = 4096,
    parameter  int MAX_LEVEL     = 15,
    localparam int SAW           = $clog2(STACK_DEPTH),
    localparam int PAW           = $clog2(PROGRAM_DEPTH),
    localparam int LVW           = $clog2(MAX_LEVEL + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tpsm_pkg::cmd_t      cmd,
    output tpsm_pkg::stat_t     stat,
    input  logic [2:0]          in_operation,
    input  logic [3:0]          in_level,
    input  logic signed [31:0]  in_operand,
    input  logic signed [31:0]  in_console_value,
    input  logic                cfg_we,
    input  logic [12:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PAW-1:0]      out_next_pc,
    output logic                out_halted,
    output logic                out_print_valid,
    output logic [1:0]          out_print_tag,
    output logic signed [31:0]  out_print_value,
    output logic                out_newline,
    output logic                out_type_error,
    output logic                out_bad_opcode
);
    import tpsm_pkg::*;

    localparam int CW = 34;

    // Tagged data stack.
    logic [CW-1:0] mem [STACK_DEPTH];

    // Architectural registers.
    logic [SAW-1:0]     base_reg;
    logic [SAW:0]       top_reg;
    logic [PAW-1:0]     pc_reg;
    logic [12:0]        plen_reg;

    // Instruction and working registers.
    logic [2:0]         op_reg;
    logic [31:0]        d_reg;
    logic [31:0]        con_reg;
    logic [LVW-1:0]     levc_reg;
    logic [SAW-1:0]     walk_reg;
    logic [CW-1:0]      rdata_reg;
    logic [CW-1:0]      ca_reg;
    logic [CW-1:0]      cb_reg;
    logic signed [31:0] ra_reg;
    logic signed [31:0] rb_reg;
    logic signed [63:0] prod_reg;
    logic               qneg_reg;
    logic               rneg_reg;

    // Results of the execute step.
    logic [CW-1:0]      res_reg;
    logic               err_reg;
    logic [PAW-1:0]     npc_reg;
    logic               we_reg;
    logic [SAW-1:0]     waddr_reg;
    logic [SAW:0]       ntop_reg;
    logic [SAW-1:0]     nbase_reg;
    logic               pv_reg;
    logic               nl_reg;
    logic               bad_reg;

    // Output register.
    logic               out_valid_reg;
    logic [PAW-1:0]     o_npc_reg;
    logic               o_halt_reg;
    logic               o_pv_reg;
    logic [1:0]         o_ptag_reg;
    logic [31:0]        o_pval_reg;
    logic               o_nl_reg;
    logic               o_err_reg;
    logic               o_bad_reg;

    // Saturate a wide signed value to 32 bits.
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Value of a numeric cell as Q16.16; an int is promoted with saturation.
    function automatic logic signed [31:0] as_real(input logic [CW-1:0] c);
        logic signed [31:0] v;
        v = c[31:0];
        if (c[33:32] != TAG_INT) begin
            return v;
        end
        if (v > 32'sd32767) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -32'sd32768) begin
            return 32'sh8000_0000;
        end
        return {v[15:0], 16'h0000};
    endfunction

    function automatic logic is_binop(input logic [31:0] fn);
        case (fn)
            FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD, FN_EQ, FN_NE, FN_LT, FN_GE,
            FN_GT, FN_LE, FN_AND, FN_OR, FN_IDIV: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Decode of the held instruction.
    logic is_indexed;
    logic op_binop;
    assign is_indexed = (d_reg == OFS_INDEXED);
    assign op_binop   = (op_reg == OP_OPR) && is_binop(d_reg);

    // Stack address arithmetic, modulo the stack depth.
    logic [SAW-1:0] top_a, top_m1, top_m2, top_p1, top_p2;
    logic [SAW-1:0] walk_d, walk_ca, walk_rdv;
    logic [PAW-1:0] pc_p1;
    assign top_a    = top_reg[SAW-1:0];
    assign top_m1   = top_a - SAW'(1);
    assign top_m2   = top_a - SAW'(2);
    assign top_p1   = top_a + SAW'(1);
    assign top_p2   = top_a + SAW'(2);
    assign walk_d   = walk_reg + d_reg[SAW-1:0];
    assign walk_ca  = walk_reg + ca_reg[SAW-1:0];
    assign walk_rdv = walk_reg + rdata_reg[SAW-1:0];
    assign pc_p1    = pc_reg + PAW'(1);

    // Status to the controller.
    assign stat.need_walk = (op_reg == OP_LOD) || (op_reg == OP_STO) || (op_reg == OP_CAL);
    assign stat.is_cal    = (op_reg == OP_CAL);
    assign stat.lev_zero  = (levc_reg == '0);
    assign stat.lev_last  = (levc_reg == LVW'(1));
    assign stat.div_op    = (op_reg == OP_OPR) &&
                            ((d_reg == FN_DIV) || (d_reg == FN_MOD) || (d_reg == FN_IDIV));
    assign stat.out_free  = !out_valid_reg || out_ready;

    // Read address selection for the walk and the two operand reads.
    logic [SAW-1:0] raddr;
    always_comb begin
        raddr = top_m1;
        if (cmd.walk_rd) begin
            raddr = walk_reg + SAW'(1);
        end else if (cmd.rd1) begin
            case (op_reg)
                OP_LOD: raddr = is_indexed ? top_m1 : walk_d;
                OP_OPR: begin
                    if (d_reg == FN_RET) begin
                        raddr = base_reg + SAW'(2);
                    end else if (op_binop) begin
                        raddr = top_m2;
                    end
                end
                default: raddr = top_m1;
            endcase
        end else if (cmd.rd2) begin
            case (op_reg)
                OP_LOD: raddr = walk_rdv;
                OP_STO: raddr = top_m2;
                OP_OPR: begin
                    if (d_reg == FN_RET) begin
                        raddr = base_reg;
                    end
                end
                default: raddr = top_m1;
            endcase
        end
    end

    // Write port selection: caller link at decode, result at commit, static link last.
    logic           mem_we;
    logic [SAW-1:0] waddr;
    logic [CW-1:0]  wdata;
    always_comb begin
        mem_we = 1'b0;
        waddr  = waddr_reg;
        wdata  = res_reg;
        if (cmd.decode && stat.is_cal) begin
            mem_we = 1'b1;
            waddr  = top_a;
            wdata  = {TAG_INT, 32'(base_reg)};
        end else if (cmd.cal_link) begin
            mem_we = 1'b1;
            waddr  = top_p1;
            wdata  = {TAG_INT, 32'(walk_reg)};
        end else if (cmd.commit) begin
            mem_we = we_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Divider operands: Q16.16 divide or integer divide and modulo.
    logic signed [31:0]   ia, ib;
    logic                 ta_int, tb_int, both_int, both_num;
    logic signed [DVD_W-1:0] dvd_s;
    logic signed [DVS_W-1:0] dvs_s;
    logic [DVD_W-1:0]     dvd_mag;
    logic [DVS_W-1:0]     dvs_mag;
    logic                 div_busy;
    logic [DVD_W-1:0]     quo;
    logic [DVS_W-1:0]     rem;

    assign ia       = ca_reg[31:0];
    assign ib       = cb_reg[31:0];
    assign ta_int   = (ca_reg[33:32] == TAG_INT);
    assign tb_int   = (cb_reg[33:32] == TAG_INT);
    assign both_int = ta_int && tb_int;
    assign both_num = (ta_int || (ca_reg[33:32] == TAG_REAL)) &&
                      (tb_int || (cb_reg[33:32] == TAG_REAL));
    assign dvd_s    = (d_reg == FN_DIV) ? {ra_reg, 16'h0000} : DVD_W'(ia);
    assign dvs_s    = (d_reg == FN_DIV) ? rb_reg : ib;
    assign dvd_mag  = dvd_s[DVD_W-1] ? DVD_W'(-dvd_s) : DVD_W'(dvd_s);
    assign dvs_mag  = dvs_s[DVS_W-1] ? DVS_W'(-dvs_s) : DVS_W'(dvs_s);
    assign stat.div_busy = div_busy;

    tpsm_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (dvd_mag),
        .divisor   (dvs_mag),
        .busy      (div_busy),
        .quotient  (quo),
        .remainder (rem)
    );

    // Multiplier operands: raw ints when both are int, promoted reals otherwise.
    logic signed [31:0] mul_x, mul_y;
    logic signed [63:0] prod_full;
    assign mul_x     = both_int ? ia : ra_reg;
    assign mul_y     = both_int ? ib : rb_reg;
    assign prod_full = 64'(mul_x) * 64'(mul_y);

    // Signed results derived from the registered product and the divider.
    logic signed [63:0] q_s, r_s, sum_s, dif_s, mulq_s;
    assign q_s    = qneg_reg ? -64'(quo) : 64'(quo);
    assign r_s    = rneg_reg ? -64'(rem) : 64'(rem);
    assign sum_s  = 64'(ra_reg) + 64'(rb_reg);
    assign dif_s  = 64'(ra_reg) - 64'(rb_reg);
    assign mulq_s = prod_reg >>> 16;

    // Binary operator on second (a) and top (b) cells.
    logic [CW-1:0] bin_res;
    logic          bin_err;
    logic signed [31:0] cx, cy;
    logic          use_real;
    logic          cmp_r;
    always_comb begin
        bin_res  = {TAG_INT, 32'h0};
        bin_err  = 1'b0;
        use_real = both_num && !both_int;
        cx       = use_real ? ra_reg : ia;
        cy       = use_real ? rb_reg : ib;
        case (d_reg)
            FN_EQ:   cmp_r = (cx == cy);
            FN_NE:   cmp_r = (cx != cy);
            FN_LT:   cmp_r = (cx < cy);
            FN_GE:   cmp_r = (cx >= cy);
            FN_GT:   cmp_r = (cx > cy);
            default: cmp_r = (cx <= cy);
        endcase
        case (d_reg)
            FN_ADD, FN_SUB, FN_MUL: begin
                if (both_int) begin
                    if (d_reg == FN_ADD) begin
                        bin_res = {TAG_INT, ca_reg[31:0] + cb_reg[31:0]};
                    end else if (d_reg == FN_SUB) begin
                        bin_res = {TAG_INT, ca_reg[31:0] - cb_reg[31:0]};
                    end else begin
                        bin_res = {TAG_INT, prod_reg[31:0]};
                    end
                end else if (both_num) begin
                    if (d_reg == FN_ADD) begin
                        bin_res = {TAG_REAL, sat32(sum_s)};
                    end else if (d_reg == FN_SUB) begin
                        bin_res = {TAG_REAL, sat32(dif_s)};
                    end else begin
                        bin_res = {TAG_REAL, sat32(mulq_s)};
                    end
                end else begin
                    bin_err = 1'b1;
                end
            end
            FN_DIV: begin
                if (!both_num) begin
                    bin_err = 1'b1;
                end else if (rb_reg == '0) begin
                    bin_err = 1'b1;
                    bin_res = {TAG_REAL, 32'h0};
                end else begin
                    bin_res = {TAG_REAL, sat32(q_s)};
                end
            end
            FN_MOD, FN_IDIV: begin
                if (!both_int) begin
                    bin_err = 1'b1;
                end else if (ib == '0) begin
                    bin_err = 1'b1;
                end else if (d_reg == FN_MOD) begin
                    bin_res = {TAG_INT, r_s[31:0]};
                end else begin
                    bin_res = {TAG_INT, q_s[31:0]};
                end
            end
            FN_EQ, FN_NE, FN_LT, FN_GE, FN_GT, FN_LE: begin
                if (!use_real && (ca_reg[33:32] != cb_reg[33:32])) begin
                    bin_err = 1'b1;
                end else begin
                    bin_res = {TAG_BOOL, 31'h0, cmp_r};
                end
            end
            FN_AND, FN_OR: begin
                if ((ca_reg[33:32] != TAG_BOOL) || (cb_reg[33:32] != TAG_BOOL)) begin
                    bin_err = 1'b1;
                end else if (d_reg == FN_AND) begin
                    bin_res = {TAG_BOOL, 31'h0, (ia != '0) && (ib != '0)};
                end else begin
                    bin_res = {TAG_BOOL, 31'h0, (ia != '0) || (ib != '0)};
                end
            end
            default: bin_err = 1'b1;
        endcase
    end

    // Execute step: result cell, write target and next register values.
    logic [CW-1:0]  ex_res;
    logic           ex_err, ex_we, ex_pv, ex_nl, ex_bad;
    logic [PAW-1:0] ex_npc;
    logic [SAW-1:0] ex_waddr, ex_base;
    logic [SAW:0]   ex_top;
    always_comb begin
        ex_res   = ca_reg;
        ex_err   = 1'b0;
        ex_we    = 1'b0;
        ex_pv    = 1'b0;
        ex_nl    = 1'b0;
        ex_bad   = 1'b0;
        ex_npc   = pc_p1;
        ex_waddr = top_a;
        ex_base  = base_reg;
        ex_top   = top_reg;
        case (op_reg)
            OP_LIT: begin
                ex_res = {TAG_INT, d_reg};
                ex_we  = 1'b1;
                ex_top = top_reg + (SAW+1)'(1);
            end
            OP_LOD: begin
                ex_we = 1'b1;
                if (is_indexed) begin
                    ex_res   = cb_reg;
                    ex_err   = !ta_int;
                    ex_waddr = top_m1;
                end else begin
                    ex_top = top_reg + (SAW+1)'(1);
                end
            end
            OP_STO: begin
                ex_we = 1'b1;
                if (is_indexed) begin
                    ex_res   = cb_reg;
                    ex_err   = !ta_int;
                    ex_waddr = walk_ca;
                    ex_top   = top_reg - (SAW+1)'(2);
                end else begin
                    ex_waddr = walk_d;
                    ex_top   = top_reg - (SAW+1)'(1);
                end
            end
            OP_CAL: begin
                ex_res   = {TAG_INT, 32'(pc_p1)};
                ex_we    = 1'b1;
                ex_waddr = top_p2;
                ex_base  = top_a;
                ex_npc   = d_reg[PAW-1:0];
            end
            OP_INT: ex_top = top_reg + d_reg[SAW:0];
            OP_JMP: ex_npc = d_reg[PAW-1:0];
            OP_JPC: begin
                if (ca_reg[33:32] != TAG_BOOL) begin
                    ex_err = 1'b1;
                end else if (ia != '0) begin
                    ex_npc = d_reg[PAW-1:0];
                end
            end
            default: begin
                case (d_reg)
                    FN_RET: begin
                        ex_top  = {1'b0, base_reg};
                        ex_npc  = ca_reg[PAW-1:0];
                        ex_base = cb_reg[SAW-1:0];
                    end
                    FN_NEG: begin
                        ex_we    = 1'b1;
                        ex_waddr = top_m1;
                        if (ta_int) begin
                            ex_res = {TAG_INT, 32'h0 - ca_reg[31:0]};
                        end else if (ca_reg[33:32] == TAG_REAL) begin
                            ex_res = {TAG_REAL, sat32(-64'(ia))};
                        end else begin
                            ex_err = 1'b1;
                            ex_res = {TAG_INT, 32'h0};
                        end
                    end
                    FN_ODD: begin
                        ex_we    = 1'b1;
                        ex_waddr = top_m1;
                        if (ta_int) begin
                            ex_res = {TAG_BOOL, 31'h0, ca_reg[0]};
                        end else begin
                            ex_err = 1'b1;
                            ex_res = {TAG_INT, 32'h0};
                        end
                    end
                    FN_NOT: begin
                        ex_we    = 1'b1;
                        ex_waddr = top_m1;
                        if (ca_reg[33:32] == TAG_BOOL) begin
                            ex_res = {TAG_BOOL, 31'h0, (ia == '0)};
                        end else begin
                            ex_err = 1'b1;
                            ex_res = {TAG_INT, 32'h0};
                        end
                    end
                    FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD, FN_EQ, FN_NE, FN_LT, FN_GE,
                    FN_GT, FN_LE, FN_AND, FN_OR, FN_IDIV: begin
                        ex_res   = bin_res;
                        ex_err   = bin_err;
                        ex_we    = 1'b1;
                        ex_waddr = top_m2;
                        ex_top   = top_reg - (SAW+1)'(1);
                    end
                    FN_PRINT:   ex_pv = 1'b1;
                    FN_NEWLINE: ex_nl = 1'b1;
                    FN_RD_INT, FN_RD_CHAR, FN_RD_REAL, FN_RD_BOOL: begin
                        ex_we  = 1'b1;
                        ex_top = top_reg + (SAW+1)'(1);
                        if (d_reg == FN_RD_INT) begin
                            ex_res = {TAG_INT, con_reg};
                        end else if (d_reg == FN_RD_CHAR) begin
                            ex_res = {TAG_CHAR, 24'h0, con_reg[7:0]};
                        end else if (d_reg == FN_RD_REAL) begin
                            ex_res = {TAG_REAL, con_reg};
                        end else begin
                            ex_res = {TAG_BOOL, 31'h0, (con_reg != '0)};
                        end
                    end
                    default: begin
                        ex_bad = 1'b1;
                        ex_npc = '0;
                    end
                endcase
            end
        endcase
    end

    // Working registers, loaded step by step under controller command.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= in_operation;
            d_reg    <= in_operand;
            con_reg  <= in_console_value;
            walk_reg <= base_reg;
            levc_reg <= (int'(in_level) > MAX_LEVEL) ? LVW'(MAX_LEVEL) : LVW'(in_level);
        end
        if (cmd.walk_wb) begin
            walk_reg <= rdata_reg[SAW-1:0];
            levc_reg <= levc_reg - LVW'(1);
        end
        if (cmd.rd2) begin
            ca_reg <= rdata_reg;
        end
        if (cmd.cap2) begin
            cb_reg <= rdata_reg;
        end
        if (cmd.prep) begin
            ra_reg <= as_real(ca_reg);
            rb_reg <= as_real(cb_reg);
        end
        if (cmd.mul) begin
            prod_reg <= prod_full;
        end
        if (cmd.div_start) begin
            qneg_reg <= dvd_s[DVD_W-1] ^ dvs_s[DVS_W-1];
            rneg_reg <= dvd_s[DVD_W-1];
        end
        if (cmd.exec) begin
            res_reg   <= ex_res;
            err_reg   <= ex_err;
            npc_reg   <= ex_npc;
            we_reg    <= ex_we;
            waddr_reg <= ex_waddr;
            ntop_reg  <= ex_top;
            nbase_reg <= ex_base;
            pv_reg    <= ex_pv;
            nl_reg    <= ex_nl;
            bad_reg   <= ex_bad;
        end
    end

    // Machine registers and program length.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            top_reg  <= '0;
            pc_reg   <= '0;
            plen_reg <= 13'd1;
        end else begin
            if (cfg_we) begin
                plen_reg <= cfg_data;
            end
            if (cmd.commit) begin
                base_reg <= nbase_reg;
                top_reg  <= ntop_reg;
                pc_reg   <= npc_reg;
            end
        end
    end

    // Output register: holds one result while the next instruction runs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            o_npc_reg  <= npc_reg;
            o_halt_reg <= (npc_reg == '0) || (int'(npc_reg) >= int'(plen_reg));
            o_pv_reg   <= pv_reg;
            o_ptag_reg <= pv_reg ? ca_reg[33:32] : 2'b00;
            o_pval_reg <= pv_reg ? ca_reg[31:0] : 32'h0;
            o_nl_reg   <= nl_reg;
            o_err_reg  <= err_reg;
            o_bad_reg  <= bad_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_next_pc     = o_npc_reg;
    assign out_halted      = o_halt_reg;
    assign out_print_valid = o_pv_reg;
    assign out_print_tag   = o_ptag_reg;
    assign out_print_value = o_pval_reg;
    assign out_newline     = o_nl_reg;
    assign out_type_error  = o_err_reg;
    assign out_bad_opcode  = o_bad_reg;

endmodule

// ===== design/tpsm_ctrl.sv =====
module tpsm_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  tpsm_pkg::stat_t stat,
    output tpsm_pkg::cmd_t  cmd
);
    import tpsm_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.decode = 1'b1;
                if (stat.need_walk && !stat.lev_zero) begin
                    state_next = S_WALK_RD;
                end else begin
                    state_next = S_RD1;
                end
            end
            S_WALK_RD: begin
                cmd.walk_rd = 1'b1;
                state_next  = S_WALK_WB;
            end
            S_WALK_WB: begin
                cmd.walk_wb = 1'b1;
                state_next  = stat.lev_last ? S_RD1 : S_WALK_RD;
            end
            S_RD1: begin
                cmd.rd1    = 1'b1;
                state_next = S_RD2;
            end
            S_RD2: begin
                cmd.rd2    = 1'b1;
                state_next = S_CAP2;
            end
            S_CAP2: begin
                cmd.cap2   = 1'b1;
                state_next = S_PREP;
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul       = 1'b1;
                cmd.div_start = stat.div_op;
                state_next    = stat.div_op ? S_DIV : S_EXEC;
            end
            S_DIV: begin
                if (!stat.div_busy) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = stat.is_cal ? S_CAL2 : S_IDLE;
                end
            end
            S_CAL2: begin
                cmd.cal_link = 1'b1;
                state_next   = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== design/typed_pcode_stack_machine.sv =====
// Typed P-code stack machine: executes one fetched instruction per request.
// Input channel s_*: one instruction per request (operation, level, operand and
// the console value used by the typed reads). Output channel m_*: one result per
// instruction with the next pc, halt flag, print and newline events and errors.
// Configuration channel cfg_*: writes program_length; always ready, and meant to
// be written only while no instruction is in flight.
// Steps: an accepted request runs decode, any static-link walk (one stack read
// and one register load per level), two operand reads and a capture, prepare,
// multiply, a wait on the one-bit-per-cycle divider for divide, mod and integer
// divide, then execute and commit, and the result appears on m_*. CAL adds a
// static-link write after its result. The single-port stack memory with
// registered read sets the step count; one instruction is in flight at a time,
// and a new one is accepted only after it commits (for CAL, after its link write).
// A result sits in an output register, so the next instruction is accepted
// while it waits; if the receiver stalls, execution holds at the commit step
// until the register frees up.
// Reset (aresetn low, synchronous) clears base, top and pc to zero, sets
// program_length to 1 and empties the output register; the stack contents are
// not cleared.
module typed_pcode_stack_machine #(
    parameter  int STACK_DEPTH   = 1024,
    parameter  int PROGRAM_DEPTH = 4096,
    parameter  int MAX_LEVEL     = 15,
    localparam int PAW           = $clog2(PROGRAM_DEPTH),
    localparam int OUT_W         = ((PAW + 39 + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    // operation[2:0], level[6:3], operand[38:7], console_value[70:39], zero pad
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [71:0]      s_tdata,
    // next_pc, halted, print_valid, print_tag[2], print_value[32], newline,
    // type_error, bad_opcode, zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [12:0]      cfg_data
);
    import tpsm_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    logic [PAW-1:0] next_pc;
    logic           halted;
    logic           print_valid;
    logic [1:0]     print_tag;
    logic [31:0]    print_value;
    logic           newline;
    logic           type_error;
    logic           bad_opcode;

    assign cfg_ready = 1'b1;

    tpsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tpsm_datapath #(
        .STACK_DEPTH   (STACK_DEPTH),
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .MAX_LEVEL     (MAX_LEVEL)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .in_operation     (s_tdata[2:0]),
        .in_level         (s_tdata[6:3]),
        .in_operand       (s_tdata[38:7]),
        .in_console_value (s_tdata[70:39]),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_next_pc      (next_pc),
        .out_halted       (halted),
        .out_print_valid  (print_valid),
        .out_print_tag    (print_tag),
        .out_print_value  (print_value),
        .out_newline      (newline),
        .out_type_error   (type_error),
        .out_bad_opcode   (bad_opcode)
    );

    // Pack the result fields from the lowest bit up.
    assign m_tdata = OUT_W'({bad_opcode, type_error, newline, print_value, print_tag,
                             print_valid, halted, next_pc});

endmodule
